>>> hdl/debounced_edge_sensor_array_top_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the debounced edge sensor array
// Each macro expands to a concurrent assertion in simulation and to nothing
// in synthesis.
// ----------------------------------------------------------------------------
`ifndef DEBOUNCED_EDGE_SENSOR_ARRAY_TOP_ASSERT_SVH
`define DEBOUNCED_EDGE_SENSOR_ARRAY_TOP_ASSERT_SVH

`ifndef SYNTHESIS
`define DES_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);
`define DES_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);
`else
`define DES_ASSERT_SAME(lbl, ante, cons, msg)
`define DES_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

>>> hdl/des_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// des_pkg
// Shared types and constants of the debounced edge sensor array.
// ----------------------------------------------------------------------------
package des_pkg;

  localparam int SAMPLE_FIELDS = 4;
  localparam int SAMPLE_W      = 15;
  localparam int THR_W         = 16;
  localparam int RUN_W         = 8;
  localparam int SUM_W         = 31;
  localparam int COUNT_W       = 16;
  localparam int CHAN_W        = 2;
  localparam int SCALE_W       = 24;
  localparam int SCALE_SHIFT   = 24;
  localparam int PROD_W        = SUM_W + SCALE_W;
  localparam int DIV_STEPS     = SUM_W;
  localparam int DIV_CNT_W     = $clog2(DIV_STEPS);

  localparam int S_DATA_W = 80;
  localparam int S_USER_W = 2;
  localparam int M_DATA_W = 8;

  localparam logic [SCALE_W-1:0] SCALE_Q24     = SCALE_W'(11744051);
  localparam logic [COUNT_W-1:0] CAL_COUNT_MAX = '1;

  typedef enum logic [1:0] {
    OP_DETECT  = 2'd0,
    OP_ACCUM   = 2'd1,
    OP_FINISH  = 2'd2,
    OP_SET_THR = 2'd3
  } op_e;

  typedef struct packed {
    logic detect;
    logic accum;
    logic set_thr;
    logic div_start;
    logic div_step;
    logic div_done;
  } lane_ctrl_t;

endpackage

>>> hdl/des_lane.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// des_lane
// One sensor channel: debounce counter, edge flag, threshold, calibration
// sum and a bit-serial divider with the 0.70 scaling multiply.
// ----------------------------------------------------------------------------
module des_lane #(
  parameter int RESET_THRESHOLD = 16000
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  des_pkg::lane_ctrl_t           ctrl_i,
  input  logic [des_pkg::SAMPLE_W-1:0]  sample_i,
  input  logic [des_pkg::RUN_W-1:0]     debounce_i,
  input  logic [des_pkg::COUNT_W-1:0]   divisor_i,
  input  logic [des_pkg::THR_W-1:0]     thr_value_i,
  output logic                          flag_o
);
  import des_pkg::*;

  logic [RUN_W-1:0]   run_q, run_d;
  logic               flag_q, flag_d;
  logic [THR_W-1:0]   thr_q, thr_d;
  logic [SUM_W-1:0]   sum_q, sum_d;
  logic [SUM_W-1:0]   div_q, div_d;
  logic [COUNT_W-1:0] rem_q, rem_d;
  logic [COUNT_W:0]   trial;
  logic               fits;
  logic [PROD_W-1:0]  prod;
  logic               below;
  logic [RUN_W-1:0]   run_inc;

  assign below   = {1'b0, sample_i} < thr_q;
  assign run_inc = (run_q < debounce_i) ? run_q + RUN_W'(1) : run_q;
  assign trial   = {rem_q, div_q[SUM_W-1]};
  assign fits    = trial >= {1'b0, divisor_i};
  assign prod    = PROD_W'(div_q) * PROD_W'(SCALE_Q24);

  always_comb begin
    run_d  = run_q;
    flag_d = flag_q;
    thr_d  = thr_q;
    sum_d  = sum_q;
    div_d  = div_q;
    rem_d  = rem_q;
    if (ctrl_i.detect) begin
      if (below) begin
        run_d  = run_inc;
        flag_d = flag_q | (run_inc >= debounce_i);
      end else begin
        run_d  = '0;
        flag_d = 1'b0;
      end
    end
    if (ctrl_i.accum) begin
      sum_d = sum_q + SUM_W'(sample_i);
    end
    if (ctrl_i.set_thr) begin
      thr_d = thr_value_i;
    end
    if (ctrl_i.div_start) begin
      div_d = sum_q;
      rem_d = '0;
    end
    if (ctrl_i.div_step) begin
      rem_d = fits ? COUNT_W'(trial - {1'b0, divisor_i}) : COUNT_W'(trial);
      div_d = {div_q[SUM_W-2:0], fits};
    end
    if (ctrl_i.div_done) begin
      thr_d = prod[SCALE_SHIFT +: THR_W];
      sum_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= '0;
      flag_q <= 1'b0;
      thr_q  <= THR_W'(RESET_THRESHOLD);
      sum_q  <= '0;
    end else begin
      run_q  <= run_d;
      flag_q <= flag_d;
      thr_q  <= thr_d;
      sum_q  <= sum_d;
    end
  end

  always_ff @(posedge clk_i) begin
    div_q <= div_d;
    rem_q <= rem_d;
  end

  assign flag_o = flag_q;

endmodule

>>> hdl/des_merge.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// des_merge
// Combines the lane flags into pattern and count and holds the result word
// in the output register until the receiver takes it.
// ----------------------------------------------------------------------------
module des_merge #(
  parameter int CHANNELS = 4
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          load_i,
  input  logic [CHANNELS-1:0]           flags_i,
  input  logic                          err_i,
  input  logic                          tready_i,
  output logic                          tvalid_o,
  output logic [des_pkg::M_DATA_W-1:0]  tdata_o
);
  import des_pkg::*;

  localparam int WIDE = 8;

  logic [WIDE-1:0]         flags_wide;
  logic [3:0]              total;
  logic                    valid_q;
  logic [M_DATA_W-1:0]     data_q;

  assign flags_wide = WIDE'(flags_i);

  always_comb begin
    total = '0;
    for (int i = 0; i < CHANNELS; i++) begin
      total = total + 4'(flags_i[i]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (load_i) begin
      valid_q <= 1'b1;
    end else if (tready_i) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      data_q <= {err_i, total[2:0], flags_wide[3:0]};
    end
  end

  assign tvalid_o = valid_q;
  assign tdata_o  = data_q;

endmodule

>>> hdl/debounced_edge_sensor_array_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// debounced_edge_sensor_array_top
// Four-channel threshold and debounce edge detector with calibration.
// ----------------------------------------------------------------------------
// The input stream carries one word per command, the command code in tuser.
// Detect words update the debounce counters and flags, accumulate words add
// to the calibration sums, finish words turn the averages into thresholds,
// and set words write one threshold. Every word gives one result word with
// the flag pattern, the flag count and the calibration error bit.
// Detect, accumulate and set words pass from the state register into the result
// register, which then raises the result. A finish word first runs through the
// bit-serial divider of each lane and then the scaling multiply. An empty
// finish skips the divider and reports its error through the report state.
// One word is in work at a time; the next is taken once the result register
// is free or being drained in the same cycle, and a stalled receiver holds
// the input side. Reset clears counters, flags, sums and the output and loads
// every threshold with its reset value; the debounce register resets to 3 and
// may be written through the configuration channel while idle.
// ----------------------------------------------------------------------------
`include "debounced_edge_sensor_array_top_assert.svh"

module debounced_edge_sensor_array_top #(
  parameter int CHANNELS        = 4,
  parameter int RESET_THRESHOLD = 16000
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid_i,
  output logic                          s_axis_tready_o,
  // sample0, sample1, sample2, sample3, channel, threshold_value, zero pad
  input  logic [des_pkg::S_DATA_W-1:0]  s_axis_tdata_i,
  // op
  input  logic [des_pkg::S_USER_W-1:0]  s_axis_tuser_i,
  output logic                          m_axis_tvalid_o,
  input  logic                          m_axis_tready_i,
  // edge_pattern, edge_count, calib_error
  output logic [des_pkg::M_DATA_W-1:0]  m_axis_tdata_o,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [des_pkg::RUN_W-1:0]     cfg_data_i
);
  import des_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIVIDE,
    ST_SCALE,
    ST_REPORT
  } state_e;

  state_e                state_q;
  logic [DIV_CNT_W-1:0]  div_cnt_q;
  logic [COUNT_W-1:0]    cal_count_q;
  logic                  err_q;
  logic [RUN_W-1:0]      debounce_q;

  logic                  s_accept;
  op_e                   op;
  logic [SAMPLE_W-1:0]   samples [SAMPLE_FIELDS];
  logic [CHAN_W-1:0]     channel;
  logic [THR_W-1:0]      thr_value;
  logic                  count_full;
  logic [CHANNELS-1:0]   flags;
  lane_ctrl_t            lane_ctrl [CHANNELS];

  assign op         = op_e'(s_axis_tuser_i);
  assign samples[0] = s_axis_tdata_i[14:0];
  assign samples[1] = s_axis_tdata_i[29:15];
  assign samples[2] = s_axis_tdata_i[44:30];
  assign samples[3] = s_axis_tdata_i[59:45];
  assign channel    = s_axis_tdata_i[61:60];
  assign thr_value  = s_axis_tdata_i[77:62];

  assign count_full      = cal_count_q == CAL_COUNT_MAX;
  assign s_axis_tready_o = (state_q == ST_IDLE) && (!m_axis_tvalid_o || m_axis_tready_i);
  assign s_accept        = s_axis_tvalid_i && s_axis_tready_o;
  assign cfg_ready_o     = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      debounce_q <= RUN_W'(3);
    end else if (cfg_valid_i) begin
      debounce_q <= cfg_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      div_cnt_q   <= '0;
      cal_count_q <= '0;
      err_q       <= 1'b0;
    end else begin
      case (state_q)
        ST_IDLE: begin
          if (s_accept) begin
            err_q   <= 1'b0;
            state_q <= ST_REPORT;
            if (op == OP_FINISH) begin
              if (cal_count_q == '0) begin
                err_q <= 1'b1;
              end else begin
                div_cnt_q <= '0;
                state_q   <= ST_DIVIDE;
              end
            end
            if (op == OP_ACCUM && !count_full) begin
              cal_count_q <= cal_count_q + COUNT_W'(1);
            end
          end
        end
        ST_DIVIDE: begin
          div_cnt_q <= div_cnt_q + DIV_CNT_W'(1);
          if (div_cnt_q == DIV_CNT_W'(DIV_STEPS - 1)) begin
            state_q <= ST_SCALE;
          end
        end
        ST_SCALE: begin
          cal_count_q <= '0;
          state_q     <= ST_REPORT;
        end
        ST_REPORT: begin
          state_q <= ST_IDLE;
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  for (genvar i = 0; i < CHANNELS; i++) begin : g_lane
    logic [SAMPLE_W-1:0] lane_sample;
    logic                lane_match;

    if (i < SAMPLE_FIELDS) begin : g_fed
      assign lane_sample = samples[i];
      assign lane_match  = channel == CHAN_W'(i);
    end else begin : g_unfed
      assign lane_sample = '0;
      assign lane_match  = 1'b0;
    end

    always_comb begin
      lane_ctrl[i].detect    = s_accept && op == OP_DETECT;
      lane_ctrl[i].accum     = s_accept && op == OP_ACCUM && !count_full;
      lane_ctrl[i].set_thr   = s_accept && op == OP_SET_THR && lane_match;
      lane_ctrl[i].div_start = s_accept && op == OP_FINISH;
      lane_ctrl[i].div_step  = state_q == ST_DIVIDE;
      lane_ctrl[i].div_done  = state_q == ST_SCALE;
    end

    des_lane #(
      .RESET_THRESHOLD(RESET_THRESHOLD)
    ) u_lane (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .ctrl_i     (lane_ctrl[i]),
      .sample_i   (lane_sample),
      .debounce_i (debounce_q),
      .divisor_i  (cal_count_q),
      .thr_value_i(thr_value),
      .flag_o     (flags[i])
    );
  end

  des_merge #(
    .CHANNELS(CHANNELS)
  ) u_merge (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .load_i  (state_q == ST_REPORT),
    .flags_i (flags),
    .err_i   (err_q),
    .tready_i(m_axis_tready_i),
    .tvalid_o(m_axis_tvalid_o),
    .tdata_o (m_axis_tdata_o)
  );

  `DES_ASSERT_SAME(a_hold_input, m_axis_tvalid_o && !m_axis_tready_i, !s_axis_tready_o,
                   "input taken while result stalled")
  `DES_ASSERT_NEXT(a_report_out, state_q == ST_REPORT, m_axis_tvalid_o,
                   "report did not raise the result")
  `DES_ASSERT_SAME(a_err_empty, m_axis_tvalid_o && m_axis_tdata_o[7], cal_count_q == '0,
                   "calibration error with samples present")

endmodule

>>> dv/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Testbench for the debounced edge sensor array
// A directed table walks the reset state, a debounce run up to its flags, the
// empty calibration error and the threshold writes, after which random bursts
// of detect runs, calibration sequences and threshold writes run under several
// debounce settings, 0 and 255 among them. Each result word is checked field by
// field against its table row or a cycle-free predictor of the flag, threshold
// and calibration state. Both stream sides stall at random.
// ----------------------------------------------------------------------------
module testbench;
  import des_pkg::*;

  localparam int WATCHDOG_LIMIT = 4000;
  localparam int TAIL_CYCLES    = 40;
  localparam int MAX_REPORTS    = 10;
  localparam longint unsigned THR_SCALE = 64'd11744051;

  typedef struct packed {
    logic       calib_error;
    logic [2:0] edge_count;
    logic [3:0] edge_pattern;
  } edge_report_t;

  typedef struct {
    op_e               op;
    logic [3:0][14:0]  smp;
    logic [1:0]        chan;
    logic [15:0]       thrv;
    bit                typed;
    edge_report_t      want;
  } dir_row_t;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                s_axis_tvalid = 1'b0;
  logic [S_DATA_W-1:0] s_axis_tdata = '0;
  logic [S_USER_W-1:0] s_axis_tuser = '0;
  logic                m_axis_tready = 1'b0;
  logic                cfg_valid = 1'b0;
  logic [RUN_W-1:0]    cfg_data = '0;
  wire                 s_axis_tready;
  wire                 m_axis_tvalid;
  wire  [M_DATA_W-1:0] m_axis_tdata;
  wire                 cfg_ready;

  logic [7:0]  run_len [4];
  logic        edge_flag [4];
  logic [15:0] thr_level [4];
  logic [30:0] cal_sum [4];
  logic [15:0] cal_n;
  logic [7:0]  debounce;

  edge_report_t pending_reports [$];
  dir_row_t     dir_rows [$];
  int           mismatches = 0;
  int           idle_cycles = 0;
  bit           calm = 1'b0;

  debounced_edge_sensor_array_top dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid),
    .s_axis_tready_o (s_axis_tready),
    .s_axis_tdata_i  (s_axis_tdata),
    .s_axis_tuser_i  (s_axis_tuser),
    .m_axis_tvalid_o (m_axis_tvalid),
    .m_axis_tready_i (m_axis_tready),
    .m_axis_tdata_o  (m_axis_tdata),
    .cfg_valid_i     (cfg_valid),
    .cfg_ready_o     (cfg_ready),
    .cfg_data_i      (cfg_data)
  );

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    m_axis_tready <= calm || ($urandom_range(99) >= 19);
  end

  task automatic note_mismatch(string msg);
    mismatches++;
    if (mismatches <= MAX_REPORTS) begin
      $display("%s", msg);
    end
  endtask

  always @(posedge clk_i) begin
    edge_report_t got;
    edge_report_t want;
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        got = m_axis_tdata;
        if (pending_reports.size() == 0) begin
          note_mismatch($sformatf("Unexpected result word %h at %0t.", got, $realtime));
        end else begin
          want = pending_reports.pop_front();
          if (got.edge_pattern !== want.edge_pattern || got.edge_count !== want.edge_count ||
              got.calib_error !== want.calib_error) begin
            note_mismatch($sformatf(
              "Mismatch at %0t: pattern %h/%h count %0d/%0d error %b/%b (expected/actual).",
              $realtime, want.edge_pattern, got.edge_pattern, want.edge_count,
              got.edge_count, want.calib_error, got.calib_error));
          end
        end
      end
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
          (cfg_valid && cfg_ready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("TB_ERROR");
        $finish;
      end
    end
  end

  function automatic edge_report_t predict_report(op_e op, logic [3:0][14:0] smp,
                                                  logic [1:0] chan, logic [15:0] thrv);
    edge_report_t r;
    logic [30:0]  avg;
    logic [63:0]  prod;
    r = '0;
    case (op)
      OP_DETECT: begin
        for (int i = 0; i < 4; i++) begin
          if ({1'b0, smp[i]} < thr_level[i]) begin
            if (run_len[i] < debounce) run_len[i]++;
            if (run_len[i] >= debounce) edge_flag[i] = 1'b1;
          end else begin
            run_len[i] = '0;
            edge_flag[i] = 1'b0;
          end
        end
      end
      OP_ACCUM: begin
        if (cal_n != 16'hFFFF) begin
          for (int i = 0; i < 4; i++) cal_sum[i] = cal_sum[i] + smp[i];
          cal_n++;
        end
      end
      OP_FINISH: begin
        if (cal_n == 0) begin
          r.calib_error = 1'b1;
        end else begin
          for (int i = 0; i < 4; i++) begin
            avg = cal_sum[i] / cal_n;
            prod = 64'(avg) * THR_SCALE;
            thr_level[i] = prod[39:24];
            cal_sum[i] = '0;
          end
          cal_n = '0;
        end
      end
      default: begin
        thr_level[chan] = thrv;
      end
    endcase
    for (int i = 0; i < 4; i++) begin
      if (edge_flag[i]) begin
        r.edge_pattern[i] = 1'b1;
        r.edge_count++;
      end
    end
    return r;
  endfunction

  task automatic send_word(op_e op, logic [3:0][14:0] smp, logic [1:0] chan,
                           logic [15:0] thrv, bit typed, edge_report_t want);
    edge_report_t expected;
    while (!calm && $urandom_range(99) < 19) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= {2'b00, thrv, chan, smp[3], smp[2], smp[1], smp[0]};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    expected = predict_report(op, smp, chan, thrv);
    pending_reports.push_back(typed ? want : expected);
  endtask

  task automatic write_debounce(logic [7:0] value);
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending_reports.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    @(posedge clk_i);
    while (!cfg_ready) @(posedge clk_i);
    cfg_valid <= 1'b0;
    debounce = value;
  endtask

  function automatic dir_row_t mk_row(op_e op, int s0, int s1, int s2, int s3, int chan,
                                      int thrv, int typed, int pat, int cnt, int err);
    dir_row_t r;
    r.op = op;
    r.smp[0] = 15'(s0);
    r.smp[1] = 15'(s1);
    r.smp[2] = 15'(s2);
    r.smp[3] = 15'(s3);
    r.chan = 2'(chan);
    r.thrv = 16'(thrv);
    r.typed = (typed != 0);
    r.want.edge_pattern = 4'(pat);
    r.want.edge_count = 3'(cnt);
    r.want.calib_error = (err != 0);
    return r;
  endfunction

  function automatic logic [14:0] pick_sample(logic [15:0] level, bit below);
    int hi;
    int lo;
    if (below && level != 0) begin
      hi = (level > 16'd32768) ? 32767 : int'(level) - 1;
      return ($urandom_range(7) == 0) ? 15'(hi) : 15'($urandom_range(hi, 0));
    end
    if (!below && level <= 16'd32767) begin
      lo = int'(level);
      return ($urandom_range(7) == 0) ? 15'(lo) : 15'($urandom_range(32767, lo));
    end
    return 15'($urandom_range(32767));
  endfunction

  task automatic random_block(int n);
    int               done;
    int               kind;
    int               len;
    int               pb;
    logic [3:0][14:0] smp;
    edge_report_t     none;
    none = '0;
    done = 0;
    while (done < n) begin
      kind = $urandom_range(99);
      if (kind < 55) begin
        len = $urandom_range(int'(debounce) + 4, 1);
        case ($urandom_range(3))
          0: pb = 100;
          1: pb = 95;
          2: pb = 60;
          default: pb = 20;
        endcase
        for (int k = 0; k < len; k++) begin
          for (int i = 0; i < 4; i++) begin
            if ($urandom_range(9) == 0) smp[i] = 15'($urandom_range(32767));
            else smp[i] = pick_sample(thr_level[i], $urandom_range(99) < pb);
          end
          send_word(OP_DETECT, smp, 2'($urandom_range(3)), 16'($urandom_range(65535)),
                    1'b0, none);
          done++;
        end
      end else if (kind < 72) begin
        len = $urandom_range(8, 1);
        for (int k = 0; k < len; k++) begin
          for (int i = 0; i < 4; i++) smp[i] = 15'($urandom_range(32767));
          send_word(OP_ACCUM, smp, 2'($urandom_range(3)), 16'($urandom_range(65535)),
                    1'b0, none);
          done++;
        end
        if ($urandom_range(1) == 0) begin
          send_word(OP_FINISH, smp, 2'($urandom_range(3)), 16'($urandom_range(65535)),
                    1'b0, none);
          done++;
        end
      end else if (kind < 80) begin
        for (int i = 0; i < 4; i++) smp[i] = 15'($urandom_range(32767));
        send_word(OP_FINISH, smp, 2'($urandom_range(3)), 16'($urandom_range(65535)),
                  1'b0, none);
        done++;
      end else if (kind < 92) begin
        for (int i = 0; i < 4; i++) smp[i] = 15'($urandom_range(32767));
        send_word(OP_SET_THR, smp, 2'($urandom_range(3)),
                  16'(($urandom_range(2) == 0) ? $urandom_range(65535) : $urandom_range(32767)),
                  1'b0, none);
        done++;
      end else begin
        for (int i = 0; i < 4; i++) smp[i] = 15'($urandom_range(32767));
        send_word(op_e'(2'($urandom_range(3))), smp, 2'($urandom_range(3)),
                  16'($urandom_range(65535)), 1'b0, none);
        done++;
      end
    end
  endtask

  initial begin
    for (int i = 0; i < 4; i++) begin
      run_len[i] = '0;
      edge_flag[i] = 1'b0;
      thr_level[i] = 16'd16000;
      cal_sum[i] = '0;
    end
    cal_n = '0;
    debounce = 8'd3;

    dir_rows.push_back(mk_row(OP_DETECT, 0, 0, 0, 0, 0, 0, 1, 'h0, 0, 0));
    dir_rows.push_back(mk_row(OP_DETECT, 0, 0, 0, 0, 3, 65535, 1, 'h0, 0, 0));
    dir_rows.push_back(mk_row(OP_DETECT, 0, 0, 0, 0, 0, 0, 1, 'hF, 4, 0));
    dir_rows.push_back(mk_row(OP_DETECT, 0, 0, 0, 0, 0, 0, 1, 'hF, 4, 0));
    dir_rows.push_back(mk_row(OP_DETECT, 32767, 0, 0, 0, 0, 0, 1, 'hE, 3, 0));
    dir_rows.push_back(mk_row(OP_DETECT, 15999, 16000, 0, 32767, 0, 0, 1, 'h4, 1, 0));
    dir_rows.push_back(mk_row(OP_FINISH, 0, 0, 0, 0, 0, 0, 1, 'h4, 1, 1));
    dir_rows.push_back(mk_row(OP_ACCUM, 32767, 32767, 32767, 32767, 0, 0, 0, 0, 0, 0));
    dir_rows.push_back(mk_row(OP_ACCUM, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    dir_rows.push_back(mk_row(OP_ACCUM, 1, 2, 3, 4, 0, 0, 0, 0, 0, 0));
    dir_rows.push_back(mk_row(OP_FINISH, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    dir_rows.push_back(mk_row(OP_DETECT, 7644, 7646, 0, 32767, 0, 0, 0, 0, 0, 0));
    dir_rows.push_back(mk_row(OP_SET_THR, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    dir_rows.push_back(mk_row(OP_SET_THR, 0, 0, 0, 0, 1, 65535, 0, 0, 0, 0));
    dir_rows.push_back(mk_row(OP_SET_THR, 0, 0, 0, 0, 2, 'h5555, 0, 0, 0, 0));
    dir_rows.push_back(mk_row(OP_SET_THR, 0, 0, 0, 0, 3, 'hAAAA, 0, 0, 0, 0));
    dir_rows.push_back(mk_row(OP_DETECT, 0, 32767, 'h2AA9, 32767, 0, 0, 0, 0, 0, 0));
    dir_rows.push_back(mk_row(OP_DETECT, 0, 32767, 'h2AA9, 32767, 0, 0, 0, 0, 0, 0));
    dir_rows.push_back(mk_row(OP_DETECT, 0, 32767, 'h2AA9, 32767, 0, 0, 0, 0, 0, 0));
    dir_rows.push_back(mk_row(OP_DETECT, 32767, 'h5555, 'h2AAA, 'h5555, 0, 0, 0, 0, 0, 0));
    dir_rows.push_back(mk_row(OP_FINISH, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    dir_rows.push_back(mk_row(OP_SET_THR, 0, 0, 0, 0, 0, 16000, 0, 0, 0, 0));
    dir_rows.push_back(mk_row(OP_ACCUM, 'h5555, 'h2AAA, 'h7FFF, 0, 1, 0, 0, 0, 0, 0));
    dir_rows.push_back(mk_row(OP_FINISH, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_rows[r]) begin
      send_word(dir_rows[r].op, dir_rows[r].smp, dir_rows[r].chan, dir_rows[r].thrv,
                dir_rows[r].typed, dir_rows[r].want);
    end

    write_debounce(8'd1);
    calm = 1'b1;
    random_block(250);
    calm = 1'b0;
    write_debounce(8'd0);
    random_block(250);
    write_debounce(8'd255);
    random_block(300);
    write_debounce(8'd2);
    random_block(250);
    write_debounce(8'($urandom_range(254, 4)));
    random_block(300);
    write_debounce(8'($urandom_range(254, 1)));
    random_block(250);

    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending_reports.size() != 0) @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
